@@ rtl/gzhp_pkg.sv @@
// gzhp_pkg: shared types and constants for the gzip member header parser
// holds the item structs, status codes, phase encoding and parser state record
// no dependencies
package gzhp_pkg;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_block;
    logic       stream_start;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
  } out_item_t;

  localparam logic [2:0] ST_HEADER    = 3'd0;
  localparam logic [2:0] ST_HDR_DONE  = 3'd1;
  localparam logic [2:0] ST_PAYLOAD   = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
  localparam logic [2:0] ST_BAD_METH  = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;
  localparam logic [2:0] ST_RAW       = 3'd6;

  localparam logic [7:0] MAGIC0     = 8'h1f;
  localparam logic [7:0] MAGIC1     = 8'h8b;
  localparam logic [7:0] METHOD_DEF = 8'h08;
  localparam logic [7:0] FLG_RSVD   = 8'hE0;
  localparam int         FLG_HCRC   = 1;
  localparam int         FLG_EXTRA  = 2;
  localparam int         FLG_NAME   = 3;
  localparam int         FLG_CMNT   = 4;
  localparam logic [3:0] FIXED_LAST = 4'd9;

  typedef enum logic [8:0] {
    PH_FIXED   = 9'b000000001,
    PH_XLO     = 9'b000000010,
    PH_XHI     = 9'b000000100,
    PH_XDATA   = 9'b000001000,
    PH_NAME    = 9'b000010000,
    PH_COMMENT = 9'b000100000,
    PH_HCRC    = 9'b001000000,
    PH_PAYLOAD = 9'b010000000,
    PH_RAW     = 9'b100000000
  } phase_t;

  // sections still to skip, in header order
  typedef struct packed {
    logic hcrc;
    logic comment;
    logic name;
    logic extra;
  } sections_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] fixed_count;
    sections_t  pending;
    logic [15:0] extra_remaining;
    logic       crc_bytes_seen;
  } pstate_t;

  localparam pstate_t PSTATE_RESET = '{
    phase:           PH_FIXED,
    fixed_count:     4'd0,
    pending:         '0,
    extra_remaining: 16'd0,
    crc_bytes_seen:  1'b0
  };

endpackage

@@ rtl/gzhp_step.sv @@
// gzhp_step: next parser state and result for one byte
// purely combinational, sits between the input and result registers
// depends on gzhp_pkg
module gzhp_step (
  input  gzhp_pkg::pstate_t   cur,
  input  gzhp_pkg::in_item_t  item,
  output gzhp_pkg::pstate_t   nxt,
  output gzhp_pkg::out_item_t res
);

  gzhp_pkg::pstate_t s;
  gzhp_pkg::phase_t  adv_phase;
  gzhp_pkg::sections_t adv_pending;
  logic              adv_done;
  logic [2:0]        err;
  logic              has_err;
  logic              done;
  logic              strict;
  logic [15:0]       ext_full;
  logic [15:0]       ext_dec;
  logic              in_hdr;

  // restart takes effect on the byte that carries it
  assign s = item.stream_start ? gzhp_pkg::PSTATE_RESET : cur;

  assign ext_full = {item.data_byte, s.extra_remaining[7:0]};
  assign ext_dec  = s.extra_remaining - 16'd1;

  // next pending section
  always_comb begin
    adv_pending = s.pending;
    adv_done    = 1'b0;
    if (s.pending.extra) begin
      adv_pending.extra = 1'b0;
      adv_phase = gzhp_pkg::PH_XLO;
    end else if (s.pending.name) begin
      adv_pending.name = 1'b0;
      adv_phase = gzhp_pkg::PH_NAME;
    end else if (s.pending.comment) begin
      adv_pending.comment = 1'b0;
      adv_phase = gzhp_pkg::PH_COMMENT;
    end else if (s.pending.hcrc) begin
      adv_pending.hcrc = 1'b0;
      adv_phase = gzhp_pkg::PH_HCRC;
    end else begin
      adv_phase = gzhp_pkg::PH_PAYLOAD;
      adv_done  = 1'b1;
    end
  end

  always_comb begin
    logic take_adv;
    take_adv     = 1'b0;
    nxt          = s;
    res.status   = gzhp_pkg::ST_HEADER;
    res.out_byte = 8'd0;
    err          = gzhp_pkg::ST_HEADER;
    has_err      = 1'b0;
    strict       = 1'b0;

    unique case (s.phase)
      gzhp_pkg::PH_PAYLOAD: begin
        res.status   = gzhp_pkg::ST_PAYLOAD;
        res.out_byte = item.data_byte;
      end
      gzhp_pkg::PH_FIXED: begin
        if (s.fixed_count == 4'd0 && item.data_byte != gzhp_pkg::MAGIC0) begin
          has_err = 1'b1;
          err     = gzhp_pkg::ST_BAD_MAGIC;
        end else if (s.fixed_count == 4'd1 && item.data_byte != gzhp_pkg::MAGIC1) begin
          has_err = 1'b1;
          err     = gzhp_pkg::ST_BAD_MAGIC;
        end else if (s.fixed_count == 4'd2 && item.data_byte != gzhp_pkg::METHOD_DEF) begin
          has_err = 1'b1;
          err     = gzhp_pkg::ST_BAD_METH;
        end else if (s.fixed_count == 4'd3) begin
          if ((item.data_byte & gzhp_pkg::FLG_RSVD) != 8'd0) begin
            has_err = 1'b1;
            err     = gzhp_pkg::ST_BAD_METH;
          end else begin
            nxt.pending.extra   = item.data_byte[gzhp_pkg::FLG_EXTRA];
            nxt.pending.name    = item.data_byte[gzhp_pkg::FLG_NAME];
            nxt.pending.comment = item.data_byte[gzhp_pkg::FLG_CMNT];
            nxt.pending.hcrc    = item.data_byte[gzhp_pkg::FLG_HCRC];
          end
        end
        nxt.fixed_count = s.fixed_count + 4'd1;
        if (!has_err && s.fixed_count >= gzhp_pkg::FIXED_LAST) begin
          take_adv = 1'b1;
        end
      end
      gzhp_pkg::PH_XLO: begin
        nxt.extra_remaining = {8'd0, item.data_byte};
        nxt.phase           = gzhp_pkg::PH_XHI;
      end
      gzhp_pkg::PH_XHI: begin
        nxt.extra_remaining = ext_full;
        if (ext_full == 16'd0) begin
          take_adv = 1'b1;
        end else begin
          nxt.phase = gzhp_pkg::PH_XDATA;
        end
      end
      gzhp_pkg::PH_XDATA: begin
        nxt.extra_remaining = ext_dec;
        if (ext_dec == 16'd0) begin
          take_adv = 1'b1;
        end
      end
      gzhp_pkg::PH_NAME, gzhp_pkg::PH_COMMENT: begin
        strict = 1'b1;
        if (item.data_byte == 8'd0) begin
          take_adv = 1'b1;
        end
      end
      gzhp_pkg::PH_HCRC: begin
        if (!s.crc_bytes_seen) begin
          nxt.crc_bytes_seen = 1'b1;
        end else begin
          take_adv = 1'b1;
        end
      end
      default: begin
        res.status   = gzhp_pkg::ST_RAW;
        res.out_byte = item.data_byte;
      end
    endcase

    done = 1'b0;
    if (take_adv) begin
      nxt.phase   = adv_phase;
      nxt.pending = adv_pending;
      done        = adv_done;
      if (adv_phase == gzhp_pkg::PH_HCRC) begin
        nxt.crc_bytes_seen = 1'b0;
      end
    end

    in_hdr = (nxt.phase != gzhp_pkg::PH_PAYLOAD) && (nxt.phase != gzhp_pkg::PH_RAW);
    if (in_hdr) begin
      if (has_err) begin
        res.status = err;
        nxt.phase  = gzhp_pkg::PH_RAW;
      end else if (item.end_of_block) begin
        res.status = gzhp_pkg::ST_TRUNC;
        nxt.phase  = gzhp_pkg::PH_RAW;
      end else begin
        res.status = gzhp_pkg::ST_HEADER;
      end
    end else if (done) begin
      // a name or comment terminator on the block's last byte still truncates
      if (item.end_of_block && strict) begin
        res.status = gzhp_pkg::ST_TRUNC;
        nxt.phase  = gzhp_pkg::PH_RAW;
      end else begin
        res.status = gzhp_pkg::ST_HDR_DONE;
      end
    end
  end

endmodule

@@ rtl/gzip_header_parser_core.sv @@
// gzip_header_parser_core: top level of the gzip member header parser
// input register, parser state, step logic and result register
// depends on gzhp_pkg and gzhp_step
//
// Takes one stream byte per item and returns one tagged result per item:
// header byte, header complete, payload, bad magic, bad method or flags,
// truncated, or raw. The pipeline is two registers deep (input register,
// then result register): an accepted item is held in the input register and
// its result is then registered in the result register, and one item per cycle
// is sustained while out_ready stays high.
// The rate is set by the single parser state register, which is updated
// once per byte as the item moves into the result register. in_ready
// follows out_ready combinationally through both stages.
module gzip_header_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gzhp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gzhp_pkg::out_item_t out_data
);

  logic                s1_valid;
  gzhp_pkg::in_item_t  s1_item;
  logic                s1_advance;
  gzhp_pkg::pstate_t   state;
  gzhp_pkg::pstate_t   state_next;
  gzhp_pkg::out_item_t res;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  gzhp_step u_step (
    .cur  (state),
    .item (s1_item),
    .nxt  (state_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= gzhp_pkg::PSTATE_RESET;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
    if (s1_advance) begin
      out_data <= res;
    end
  end

  // a byte only passes through for payload and raw results
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.out_byte == 8'd0 || out_data.status == gzhp_pkg::ST_PAYLOAD
                   || out_data.status == gzhp_pkg::ST_RAW))
    else $error("out_byte set on a header or error result");

  // an error result leaves the parser in raw
  a_err_raw: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && (res.status == gzhp_pkg::ST_BAD_MAGIC || res.status == gzhp_pkg::ST_BAD_METH
                    || res.status == gzhp_pkg::ST_TRUNC))
    |=> (state.phase == gzhp_pkg::PH_RAW))
    else $error("parser not raw after an error");

  // parser state moves only with an item
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(state))
    else $error("parser state changed without an item");

  // empty result register never blocks the input
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // the fixed header never runs past its last byte
  a_fixed_range: assert property (@(posedge clk) disable iff (rst)
    (state.phase == gzhp_pkg::PH_FIXED) |-> (state.fixed_count <= gzhp_pkg::FIXED_LAST))
    else $error("fixed header count out of range");

endmodule
